>>> rtl/palette_chroma_key_hasher_unit_defines.svh
// assertion macros for the palette chroma key hasher
// used by the top level, no other dependencies
`ifndef PALETTE_CHROMA_KEY_HASHER_UNIT_DEFINES_SVH
`define PALETTE_CHROMA_KEY_HASHER_UNIT_DEFINES_SVH

// same-cycle implication, disabled in reset
`define PCHK_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("pchk assertion failed");

// next-cycle implication, disabled in reset
`define PCHK_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("pchk assertion failed");

`endif

>>> rtl/pchk_pkg.sv
// shared types, codes and constants for the palette chroma key hasher
// no dependencies
`default_nettype none

package pchk_pkg;

   localparam int PALETTE_ENTRIES = 256;
   localparam int ADDR_W          = (PALETTE_ENTRIES > 2) ? $clog2(PALETTE_ENTRIES) : 1;
   localparam int INDEX_W         = 8;
   // compare width covering both the index field and the entry count
   localparam int CMP_W           = ((ADDR_W > INDEX_W) ? ADDR_W : INDEX_W) + 1;
   localparam int WORD_W          = 32;
   localparam int KEY_W           = 24;
   localparam int CSR_IDX_W       = 2;

   localparam logic [WORD_W-1:0] RGB_MASK   = 32'h00ff_ffff;
   localparam logic [WORD_W-1:0] ALPHA_MASK = 32'hff00_0000;

   // item action codes
   localparam logic [1:0] ACT_WRITE = 2'd0;
   localparam logic [1:0] ACT_APPLY = 2'd1;
   localparam logic [1:0] ACT_READ  = 2'd2;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_KEY_COLOUR  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_KEY_ENABLE  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_ALPHA_ONLY  = 2'd2;

   // result kinds
   localparam logic RK_HASH  = 1'b0;
   localparam logic RK_ENTRY = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ,
      ST_WALK,
      ST_RESP
   } state_type;

   typedef struct packed {
      logic              en;
      logic [ADDR_W-1:0] addr;
      logic [WORD_W-1:0] data;
   } pchk_wr_type;

   typedef struct packed {
      logic [KEY_W-1:0] colour;
      logic             enable;
      logic             alpha_only;
   } pchk_key_cfg_type;

endpackage

`default_nettype wire

>>> rtl/pchk_palette_ram.sv
// palette store: one write port, one registered read port, per-entry valid bits
// depends on pchk_pkg
`default_nettype none

module pchk_palette_ram
   import pchk_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire pchk_wr_type       wr,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [WORD_W-1:0] rd_data
);

   logic [WORD_W-1:0] palette_mem [PALETTE_ENTRIES];
   logic [PALETTE_ENTRIES-1:0] valid_ff;
   logic [WORD_W-1:0] rd_data_ff;
   logic              rd_valid_ff;

   // memory array write and registered read
   always_ff @(posedge clock) begin
      if (wr.en) begin
         palette_mem[wr.addr] <= wr.data;
      end
      rd_data_ff <= palette_mem[rd_addr];
   end

   // valid bits, cleared at reset so unwritten entries read as zero
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         if (wr.en) begin
            valid_ff[wr.addr] <= 1'b1;
         end
         rd_valid_ff <= valid_ff[rd_addr];
      end
   end

   assign rd_data = rd_valid_ff ? rd_data_ff : '0;

endmodule

`default_nettype wire

>>> rtl/pchk_key_hash.sv
// shared keying and rotate-add hash step, with the hash accumulator
// depends on pchk_pkg
`default_nettype none

module pchk_key_hash
   import pchk_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              clear,
   input  wire logic              step,
   input  wire pchk_key_cfg_type  cfg,
   input  wire logic [WORD_W-1:0] entry,
   output logic      [WORD_W-1:0] keyed,
   output logic      [WORD_W-1:0] hash
);

   logic [WORD_W-1:0] hash_ff;
   logic [WORD_W-1:0] hash_in;
   logic [WORD_W-1:0] term;
   logic              match;

   // chroma key compare on the colour bits
   always_comb begin
      match = cfg.enable && (entry[KEY_W-1:0] == cfg.colour);
      keyed = match ? (entry & RGB_MASK) : (entry | ALPHA_MASK);
      term  = cfg.alpha_only ? (keyed & ALPHA_MASK) : keyed;
   end

   // rotate left by five then add
   always_comb begin
      hash_in = hash_ff;
      if (clear) begin
         hash_in = '0;
      end else if (step) begin
         hash_in = {hash_ff[WORD_W-6:0], hash_ff[WORD_W-1:WORD_W-5]} + term;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hash_ff <= '0;
      end else begin
         hash_ff <= hash_in;
      end
   end

   assign hash = hash_ff;

endmodule

`default_nettype wire

>>> rtl/palette_chroma_key_hasher_unit.sv
// Palette chroma key hasher, top level with sequencer and result register.
// Items arrive on req_* and results leave on rsp_*, both valid/ready; registers
// are written on csr_* (index 0 key colour, 1 key enable, 2 alpha-only hash),
// always ready and meant to be written while the block is idle.
// A write item gives no result. A read item passes through the registered
// palette read, then the result entry register, then the output register.
// An apply on an unchanged palette goes from ST_IDLE to ST_RESP and reports
// the stored hash. An apply after any entry or key change walks the palette
// through the shared key and hash step, one entry per cycle on the memory's
// read port with write-back on its write port, before the result is loaded.
// The block takes one item at a time; req_ready is high only between items.
// A result waiting in the output register does not hold off the next item;
// the block only stalls when a new result is ready and the register is full.
// Reset clears the palette through per-entry valid bits at once (no clearing
// pass), zeroes the stored hash, key registers and result valid flag, and marks the palette for rekey.
`default_nettype none
`include "palette_chroma_key_hasher_unit_defines.svh"

module palette_chroma_key_hasher_unit
   import pchk_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   // item input
   input  wire logic                 req_valid,
   output logic                      req_ready,
   input  wire logic [1:0]           req_action,
   input  wire logic [INDEX_W-1:0]   req_entry_index,
   input  wire logic [WORD_W-1:0]    req_entry_value,
   // result output
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   output logic                      rsp_result_kind,
   output logic      [WORD_W-1:0]    rsp_palette_hash,
   output logic      [WORD_W-1:0]    rsp_entry_out,
   // register writes
   input  wire logic                 csr_valid,
   output logic                      csr_ready,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [WORD_W-1:0]    csr_wdata
);

   state_type state_ff, state_in;

   logic [ADDR_W-1:0] cnt_ff, cnt_in;
   logic              rekey_ff, rekey_in;
   logic              in_range_ff, in_range_in;
   logic              res_kind_ff, res_kind_in;
   logic [WORD_W-1:0] res_entry_ff, res_entry_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              rsp_kind_ff, rsp_kind_in;
   logic [WORD_W-1:0] rsp_hash_ff, rsp_hash_in;
   logic [WORD_W-1:0] rsp_entry_ff, rsp_entry_in;
   pchk_key_cfg_type  cfg_ff, cfg_in;

   logic              accept;
   logic              csr_wr;
   logic              idx_ok;
   logic              last;
   logic              slot_free;
   pchk_wr_type       mem_wr;
   logic [ADDR_W-1:0] rd_addr;
   logic [WORD_W-1:0] rd_data;
   logic              hash_clear;
   logic              hash_step;
   logic [WORD_W-1:0] keyed;
   logic [WORD_W-1:0] hash;

   assign accept    = req_valid && req_ready;
   assign csr_ready = 1'b1;
   assign csr_wr    = csr_valid && csr_ready;
   assign idx_ok    = CMP_W'(req_entry_index) < CMP_W'(PALETTE_ENTRIES);
   assign last      = (cnt_ff == ADDR_W'(PALETTE_ENTRIES - 1));
   assign slot_free = !rsp_valid_ff || rsp_ready;

   pchk_palette_ram u_ram (
      .clock   (clock),
      .reset   (reset),
      .wr      (mem_wr),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   pchk_key_hash u_key_hash (
      .clock (clock),
      .reset (reset),
      .clear (hash_clear),
      .step  (hash_step),
      .cfg   (cfg_ff),
      .entry (rd_data),
      .keyed (keyed),
      .hash  (hash)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req_action)
                  ACT_APPLY: state_in = rekey_ff ? ST_WALK : ST_RESP;
                  ACT_READ:  state_in = ST_READ;
                  default:   state_in = ST_IDLE;
               endcase
            end
         end
         ST_READ: state_in = ST_RESP;
         ST_WALK: state_in = last ? ST_RESP : ST_WALK;
         ST_RESP: state_in = slot_free ? ST_IDLE : ST_RESP;
         default: state_in = ST_IDLE;
      endcase
   end

   // sequencer outputs: memory ports and hash step control
   always_comb begin
      req_ready   = 1'b0;
      mem_wr.en   = 1'b0;
      mem_wr.addr = cnt_ff;
      mem_wr.data = keyed;
      rd_addr     = cnt_ff;
      hash_clear  = 1'b0;
      hash_step   = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready   = 1'b1;
            mem_wr.en   = accept && (req_action == ACT_WRITE) && idx_ok;
            mem_wr.addr = ADDR_W'(req_entry_index);
            mem_wr.data = req_entry_value;
            rd_addr     = (req_action == ACT_APPLY) ? '0 : ADDR_W'(req_entry_index);
            hash_clear  = accept && (req_action == ACT_APPLY) && rekey_ff;
         end
         ST_WALK: begin
            mem_wr.en = 1'b1;
            rd_addr   = cnt_ff + ADDR_W'(1);
            hash_step = 1'b1;
         end
         default: begin
            mem_wr.en = 1'b0;
         end
      endcase
   end

   // item bookkeeping, rekey mark and register file
   always_comb begin
      cnt_in       = cnt_ff;
      rekey_in     = rekey_ff;
      in_range_in  = in_range_ff;
      res_kind_in  = res_kind_ff;
      res_entry_in = res_entry_ff;
      cfg_in       = cfg_ff;
      if (accept) begin
         cnt_in       = '0;
         in_range_in  = idx_ok;
         res_kind_in  = (req_action == ACT_READ) ? RK_ENTRY : RK_HASH;
         res_entry_in = '0;
         if ((req_action == ACT_WRITE) && idx_ok) begin
            rekey_in = 1'b1;
         end
      end
      if (state_ff == ST_READ) begin
         res_entry_in = in_range_ff ? rd_data : '0;
      end
      if (state_ff == ST_WALK) begin
         cnt_in = cnt_ff + ADDR_W'(1);
         if (last) begin
            rekey_in = 1'b0;
         end
      end
      if (csr_wr) begin
         case (csr_index)
            REG_KEY_COLOUR: begin
               cfg_in.colour = csr_wdata[KEY_W-1:0];
               rekey_in      = 1'b1;
            end
            REG_KEY_ENABLE: begin
               cfg_in.enable = csr_wdata[0];
               rekey_in      = 1'b1;
            end
            REG_ALPHA_ONLY: cfg_in.alpha_only = csr_wdata[0];
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   // output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_kind_in  = rsp_kind_ff;
      rsp_hash_in  = rsp_hash_ff;
      rsp_entry_in = rsp_entry_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if ((state_ff == ST_RESP) && slot_free) begin
         rsp_valid_in = 1'b1;
         rsp_kind_in  = res_kind_ff;
         rsp_hash_in  = hash;
         rsp_entry_in = res_entry_ff;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rekey_ff     <= 1'b1;
         rsp_valid_ff <= 1'b0;
         cfg_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         rekey_ff     <= rekey_in;
         rsp_valid_ff <= rsp_valid_in;
         cfg_ff       <= cfg_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      cnt_ff       <= cnt_in;
      in_range_ff  <= in_range_in;
      res_kind_ff  <= res_kind_in;
      res_entry_ff <= res_entry_in;
      rsp_kind_ff  <= rsp_kind_in;
      rsp_hash_ff  <= rsp_hash_in;
      rsp_entry_ff <= rsp_entry_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_result_kind  = rsp_kind_ff;
   assign rsp_palette_hash = rsp_hash_ff;
   assign rsp_entry_out    = rsp_entry_ff;

   // an apply on an unmarked palette goes straight to the result
   `PCHK_ASSERT_NEXT(a_apply_clean, clock, reset,
      accept && (req_action == ACT_APPLY) && !rekey_ff, state_ff == ST_RESP)
   // an apply on a marked palette starts the walk at entry zero
   `PCHK_ASSERT_NEXT(a_apply_walk, clock, reset,
      accept && (req_action == ACT_APPLY) && rekey_ff,
      (state_ff == ST_WALK) && (cnt_ff == '0))
   // the walk ends at the last entry and clears the mark
   `PCHK_ASSERT_NEXT(a_walk_done, clock, reset,
      (state_ff == ST_WALK) && last, (state_ff == ST_RESP) && !rekey_ff)
   // an in-range write marks the palette for rekeying
   `PCHK_ASSERT_NEXT(a_write_marks, clock, reset,
      accept && (req_action == ACT_WRITE) && idx_ok, rekey_ff)

endmodule

`default_nettype wire

>>> tb/palette_check_pkg.sv
// prediction and checking of palette chroma key hasher results
// depends on pchk_pkg for widths, action codes, register indexes and result kinds
package palette_check_pkg;
   timeunit 1ns;
   timeprecision 1ps;

   import pchk_pkg::*;

   // codes the block has no use for
   localparam logic [1:0]           ACT_SPARE = 2'd3;
   localparam logic [CSR_IDX_W-1:0] REG_SPARE = 2'd3;

   typedef struct packed {
      logic              kind;
      logic [WORD_W-1:0] hash;
      logic [WORD_W-1:0] entry;
   } palette_report_type;

   // own copy of the palette, key settings and hash, plus reports still due
   class palette_key_tracker;
      logic [WORD_W-1:0]  palette [PALETTE_ENTRIES];
      logic [WORD_W-1:0]  hash_now;
      bit                 rekey_due;
      logic [KEY_W-1:0]   key_colour;
      bit                 key_on;
      bit                 alpha_only_hash;
      palette_report_type awaited_reports [$];
      int unsigned        mismatches;

      function new();
         foreach (palette[i]) palette[i] = '0;
         hash_now        = '0;
         rekey_due       = 1'b1;
         key_colour      = '0;
         key_on          = 1'b0;
         alpha_only_hash = 1'b0;
         mismatches      = 0;
      endfunction

      // colour and enable writes mark the palette, the hash mode does not
      function void note_register(logic [CSR_IDX_W-1:0] idx, logic [WORD_W-1:0] data);
         case (idx)
            REG_KEY_COLOUR: begin
               key_colour = data[KEY_W-1:0];
               rekey_due  = 1'b1;
            end
            REG_KEY_ENABLE: begin
               key_on    = data[0];
               rekey_due = 1'b1;
            end
            REG_ALPHA_ONLY: alpha_only_hash = data[0];
            default: ;
         endcase
      endfunction

      // walk the palette in index order, clear alpha on key matches, force it elsewhere, fold in rotl-5-add
      function void rekey_and_hash();
         logic [WORD_W-1:0] e;
         logic [WORD_W-1:0] h;
         h = '0;
         for (int i = 0; i < PALETTE_ENTRIES; i++) begin
            e = palette[i];
            if (key_on && e[KEY_W-1:0] == key_colour) e = e & RGB_MASK;
            else e = e | ALPHA_MASK;
            palette[i] = e;
            h = {h[WORD_W-6:0], h[WORD_W-1:WORD_W-5]};
            h = h + (alpha_only_hash ? (e & ALPHA_MASK) : e);
         end
         hash_now  = h;
         rekey_due = 1'b0;
      endfunction

      function void note_item(logic [1:0] act, logic [INDEX_W-1:0] idx,
                              logic [WORD_W-1:0] val);
         palette_report_type rep;
         case (act)
            ACT_WRITE: begin
               if (idx < PALETTE_ENTRIES) begin
                  palette[idx] = val;
                  rekey_due    = 1'b1;
               end
            end
            ACT_APPLY: begin
               if (rekey_due) rekey_and_hash();
               rep.kind  = RK_HASH;
               rep.hash  = hash_now;
               rep.entry = '0;
               awaited_reports.push_back(rep);
            end
            ACT_READ: begin
               rep.kind  = RK_ENTRY;
               rep.hash  = hash_now;
               rep.entry = (idx < PALETTE_ENTRIES) ? palette[idx] : '0;
               awaited_reports.push_back(rep);
            end
            default: ;
         endcase
      endfunction

      // compare one accepted result with the oldest report due
      function void check_report(logic kind, logic [WORD_W-1:0] hash,
                                 logic [WORD_W-1:0] entry);
         palette_report_type rep;
         if (awaited_reports.size() == 0) begin
            mismatches++;
            $display("%0t: result with no item waiting: kind %0d hash %08h entry %08h",
                     $time, kind, hash, entry);
            return;
         end
         rep = awaited_reports.pop_front();
         if (kind !== rep.kind) begin
            mismatches++;
            $display("%0t: result_kind mismatch, expected %0d, actual %0d",
                     $time, rep.kind, kind);
         end
         if (hash !== rep.hash) begin
            mismatches++;
            $display("%0t: palette_hash mismatch, expected %08h, actual %08h",
                     $time, rep.hash, hash);
         end
         if (entry !== rep.entry) begin
            mismatches++;
            $display("%0t: entry_out mismatch, expected %08h, actual %08h",
                     $time, rep.entry, entry);
         end
      endfunction

      function int unsigned outstanding();
         return awaited_reports.size();
      endfunction
   endclass

endpackage

>>> tb/tb_palette_chroma_key_hasher_unit.sv
// top-level testbench for palette_chroma_key_hasher_unit: directed and random items
// with random idling on both channels; depends on pchk_pkg and palette_check_pkg
module tb_palette_chroma_key_hasher_unit;
   timeunit 1ns;
   timeprecision 1ps;

   import pchk_pkg::*;
   import palette_check_pkg::*;

   localparam int unsigned ITEM_TARGET   = 950;
   localparam int unsigned HOLD_CYCLES   = 600;
   localparam int unsigned SETTLE_CYCLES = 16;
   localparam int unsigned END_CYCLES    = 300;
   localparam int unsigned CYCLE_LIMIT   = 2_000_000;

   logic                 clock;
   logic                 reset;
   logic                 req_valid;
   logic                 req_ready;
   logic [1:0]           req_action;
   logic [INDEX_W-1:0]   req_entry_index;
   logic [WORD_W-1:0]    req_entry_value;
   logic                 rsp_valid;
   logic                 rsp_ready;
   logic                 rsp_result_kind;
   logic [WORD_W-1:0]    rsp_palette_hash;
   logic [WORD_W-1:0]    rsp_entry_out;
   logic                 csr_valid;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [WORD_W-1:0]    csr_wdata;

   palette_key_tracker tracker;
   bit                 quiet;
   bit                 hold_request;
   int unsigned        items_sent;
   int unsigned        cycle_count;

   palette_chroma_key_hasher_unit uut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_action       (req_action),
      .req_entry_index  (req_entry_index),
      .req_entry_value  (req_entry_value),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_result_kind  (rsp_result_kind),
      .rsp_palette_hash (rsp_palette_hash),
      .rsp_entry_out    (rsp_entry_out),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   // clock
   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("palette_chroma_key_hasher_unit regression: fail");
         $finish;
      end
   end

   // mostly short gaps, a few long ones, none while quiet
   function automatic int unsigned pick_gap();
      int unsigned roll;
      if (quiet) return 0;
      roll = $urandom_range(0, 99);
      if (roll < 55) return 0;
      if (roll < 90) return $urandom_range(1, 3);
      if (roll < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // indices bunch up at the ends so reads tend to hit written entries
   function automatic logic [INDEX_W-1:0] pick_index();
      case ($urandom_range(0, 9))
         0, 1, 2, 3: return INDEX_W'($urandom_range(0, 7));
         4:          return '1;
         5:          return '0;
         default:    return INDEX_W'($urandom_range(0, 255));
      endcase
   endfunction

   // entry values: key matches, near misses, extremes and plain random words
   function automatic logic [WORD_W-1:0] pick_entry();
      logic [WORD_W-1:0] word;
      word = $urandom;
      case ($urandom_range(0, 9))
         0, 1, 2: word[KEY_W-1:0] = tracker.key_colour;
         3:       word[KEY_W-1:0] = tracker.key_colour ^ (24'h1 << $urandom_range(0, 23));
         4:       word = '0;
         5:       word = '1;
         default: ;
      endcase
      return word;
   endfunction

   // offer one item and hold it until taken, then maybe idle
   task automatic offer_item(input logic [1:0] act, input logic [INDEX_W-1:0] idx,
                             input logic [WORD_W-1:0] val);
      int unsigned gap;
      req_valid       <= 1'b1;
      req_action      <= act;
      req_entry_index <= idx;
      req_entry_value <= val;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      if (act != ACT_SPARE) items_sent++;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // one edge first so the monitor has noted the last accepted item
   task automatic wait_until_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (tracker.outstanding() != 0) @(posedge clock);
   endtask

   // registers change only once the block has gone quiet
   task automatic idle_for_registers();
      wait_until_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(input logic [CSR_IDX_W-1:0] idx,
                                 input logic [WORD_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // stale or fresh hash first, then a key-matching entry keyed and read back
   task automatic open_phase();
      logic [INDEX_W-1:0] spot;
      logic [WORD_W-1:0]  word;
      spot = pick_index();
      word = $urandom;
      word[KEY_W-1:0] = tracker.key_colour;
      offer_item(ACT_APPLY, '0, '0);
      offer_item(ACT_WRITE, spot, word);
      offer_item(ACT_APPLY, spot, word);
      offer_item(ACT_READ, spot, '0);
      offer_item(ACT_APPLY, '1, '1);
      offer_item(ACT_READ, pick_index(), $urandom);
   endtask

   // bursts of writes, an apply and read-back, mixed with loose items
   task automatic run_random_items(input int unsigned count, input bit pause_midway);
      int unsigned        sent;
      int unsigned        roll;
      int unsigned        burst;
      bit                 paused;
      logic [1:0]         act;
      logic [INDEX_W-1:0] spots [6];
      sent   = 0;
      paused = 1'b0;
      while (sent < count) begin
         if (pause_midway && !paused && sent >= count / 2) begin
            wait_until_drained();
            paused = 1'b1;
         end
         roll = $urandom_range(0, 99);
         if (roll < 60) begin
            burst = $urandom_range(1, 6);
            for (int k = 0; k < burst; k++) begin
               spots[k] = pick_index();
               offer_item(ACT_WRITE, spots[k], pick_entry());
            end
            offer_item(ACT_APPLY, pick_index(), $urandom);
            for (int k = 0; k < burst; k++) offer_item(ACT_READ, spots[k], $urandom);
            sent += 2 * burst + 1;
         end else begin
            roll = $urandom_range(0, 99);
            if (roll < 45)      act = ACT_WRITE;
            else if (roll < 75) act = ACT_READ;
            else if (roll < 93) act = ACT_APPLY;
            else                act = ACT_SPARE;
            offer_item(act, pick_index(), pick_entry());
            if (act != ACT_SPARE) sent++;
         end
      end
      offer_item(ACT_APPLY, pick_index(), $urandom);
   endtask

   // item and result monitor
   always @(posedge clock) begin
      if (!reset) begin
         if (csr_valid && csr_ready) tracker.note_register(csr_index, csr_wdata);
         if (req_valid && req_ready)
            tracker.note_item(req_action, req_entry_index, req_entry_value);
         if (rsp_valid && rsp_ready)
            tracker.check_report(rsp_result_kind, rsp_palette_hash, rsp_entry_out);
      end
   end

   // result receiver, with one long hold-off on request
   initial begin : result_sink
      int unsigned stall;
      rsp_ready = 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (hold_request) begin
            hold_request = 1'b0;
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else begin
            stall = pick_gap();
            if (stall > 0) begin
               rsp_ready <= 1'b0;
               repeat (stall) @(posedge clock);
            end
            rsp_ready <= 1'b1;
            repeat ($urandom_range(1, 12)) @(posedge clock);
         end
      end
   end

   // stimulus
   initial begin : stimulus
      tracker         = new();
      quiet           = 1'b0;
      hold_request    = 1'b0;
      items_sent      = 0;
      reset           = 1'b1;
      req_valid       = 1'b0;
      req_action      = ACT_WRITE;
      req_entry_index = '0;
      req_entry_value = '0;
      csr_valid       = 1'b0;
      csr_index       = REG_KEY_COLOUR;
      csr_wdata       = '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset settings: zeroed palette, first walk, unmarked apply, ignored action
      offer_item(ACT_READ, '0, '0);
      offer_item(ACT_READ, '1, '1);
      offer_item(ACT_APPLY, '0, '0);
      offer_item(ACT_APPLY, '1, '1);
      offer_item(ACT_READ, 8'd17, '0);
      offer_item(ACT_WRITE, '0, '0);
      offer_item(ACT_WRITE, '1, '1);
      offer_item(ACT_WRITE, 8'd1, 32'h1234_5678);
      offer_item(ACT_READ, 8'd1, '0);
      offer_item(ACT_SPARE, 8'd1, $urandom);
      offer_item(ACT_SPARE, '1, '1);
      offer_item(ACT_READ, 8'd1, '0);
      offer_item(ACT_APPLY, '0, '0);
      offer_item(ACT_READ, '0, '0);
      offer_item(ACT_READ, '1, '0);
      offer_item(ACT_READ, 8'd1, '0);
      offer_item(ACT_WRITE, 8'd128, 32'h00ff_ffff);
      offer_item(ACT_APPLY, '0, '0);
      offer_item(ACT_READ, 8'd128, '0);
      run_random_items(140, 1'b0);

      // keying on at a random colour, full-word hash
      idle_for_registers();
      write_register(REG_KEY_COLOUR, $urandom);
      write_register(REG_KEY_ENABLE, $urandom | 32'h1);
      write_register(REG_ALPHA_ONLY, $urandom & ~32'h1);
      open_phase();
      run_random_items(150, 1'b0);

      // hash mode alone changes: the next apply still reports the old hash
      idle_for_registers();
      write_register(REG_ALPHA_ONLY, $urandom | 32'h1);
      open_phase();
      run_random_items(150, 1'b1);

      // all-ones extremes and a write to the unused register
      idle_for_registers();
      write_register(REG_KEY_COLOUR, '1);
      write_register(REG_KEY_ENABLE, '1);
      write_register(REG_ALPHA_ONLY, '1);
      write_register(REG_SPARE, $urandom);
      open_phase();
      run_random_items(150, 1'b0);

      // black key, and the receiver holds off while items keep coming
      idle_for_registers();
      write_register(REG_KEY_COLOUR, '0);
      write_register(REG_KEY_ENABLE, 32'h1);
      write_register(REG_ALPHA_ONLY, '0);
      open_phase();
      hold_request = 1'b1;
      run_random_items(150, 1'b0);

      // keying off, no idling on either side
      idle_for_registers();
      quiet = 1'b1;
      write_register(REG_KEY_ENABLE, $urandom & ~32'h1);
      write_register(REG_KEY_COLOUR, $urandom);
      open_phase();
      run_random_items(100, 1'b0);
      idle_for_registers();
      quiet = 1'b0;

      // random settings for the rest
      write_register(REG_KEY_COLOUR, $urandom);
      write_register(REG_KEY_ENABLE, $urandom);
      write_register(REG_ALPHA_ONLY, $urandom);
      write_register(REG_SPARE, $urandom);
      open_phase();
      if (items_sent < ITEM_TARGET) run_random_items(ITEM_TARGET - items_sent, 1'b0);

      // drain, then give any stray result time to show up
      wait_until_drained();
      repeat (END_CYCLES) @(posedge clock);
      if (tracker.mismatches == 0 && tracker.outstanding() == 0) begin
         $display("palette_chroma_key_hasher_unit regression: pass");
      end else begin
         $display("palette_chroma_key_hasher_unit regression: fail");
      end
      $finish;
   end

endmodule
